### rtl/fhb_pkg.sv
package fhb_pkg;

  localparam int unsigned FRAME_W = 16;
  localparam int unsigned DAY_W   = 10;
  localparam int unsigned SECS_W  = 17;
  localparam int unsigned FRAC_W  = 14;

  localparam int unsigned DAY_DIGITS  = 3;
  localparam int unsigned SECS_DIGITS = 5;
  localparam int unsigned FRAC_DIGITS = 4;

  localparam int unsigned DAY_BCD_W  = 4 * DAY_DIGITS;
  localparam int unsigned SECS_BCD_W = 4 * SECS_DIGITS;
  localparam int unsigned FRAC_BCD_W = 4 * FRAC_DIGITS;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned MSG_W   = 48;

  localparam logic [WORD_W-1:0] SYNC_WORD    = 32'habaddeed;
  localparam logic [15:0]       FRAME_MARKER = 16'hbead;
  localparam logic [CRC_W-1:0]  CRC_POLY     = 16'h4003;

  localparam int unsigned BCD_STAGES         = 3;
  localparam int unsigned BCD_BITS_PER_STAGE = 6;
  localparam int unsigned CRC_STAGES         = 6;
  localparam int unsigned CRC_BITS_PER_STAGE = MSG_W / CRC_STAGES;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [DAY_W-1:0]   day_number;
    logic [SECS_W-1:0]  seconds_of_day;
    logic [FRAC_W-1:0]  tenth_milliseconds;
  } hdr_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0]    frame_number;
    logic [DAY_BCD_W-1:0]  day_bcd;
    logic [SECS_BCD_W-1:0] secs_bcd;
    logic [FRAC_BCD_W-1:0] frac_bcd;
  } bcd_t;

  typedef struct packed {
    logic [WORD_W-1:0] sync_word;
    logic [WORD_W-1:0] frame_word;
    logic [WORD_W-1:0] time_word;
    logic [WORD_W-1:0] fraction_crc_word;
  } hdr_out_t;

endpackage

### rtl/fhb_in_if.sv
interface fhb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_number;
  logic [9:0]  day_number;
  logic [16:0] seconds_of_day;
  logic [13:0] tenth_milliseconds;

  modport source (
    output valid, frame_number, day_number, seconds_of_day, tenth_milliseconds,
    input  ready
  );
  modport sink (
    input  valid, frame_number, day_number, seconds_of_day, tenth_milliseconds,
    output ready
  );
endinterface

### rtl/fhb_out_if.sv
interface fhb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sync_word;
  logic [31:0] frame_word;
  logic [31:0] time_word;
  logic [31:0] fraction_crc_word;

  modport source (
    output valid, sync_word, frame_word, time_word, fraction_crc_word,
    input  ready
  );
  modport sink (
    input  valid, sync_word, frame_word, time_word, fraction_crc_word,
    output ready
  );
endinterface

### rtl/fhb_bcd.sv
module fhb_bcd (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  fhb_pkg::hdr_in_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output fhb_pkg::bcd_t   data_o
);

  localparam int unsigned NS = fhb_pkg::BCD_STAGES;

  typedef struct packed {
    logic [fhb_pkg::FRAME_W-1:0]    frame_number;
    logic [fhb_pkg::DAY_W-1:0]      day_bin;
    logic [fhb_pkg::SECS_W-1:0]     secs_bin;
    logic [fhb_pkg::FRAC_W-1:0]     frac_bin;
    logic [fhb_pkg::DAY_BCD_W-1:0]  day_bcd;
    logic [fhb_pkg::SECS_BCD_W-1:0] secs_bcd;
    logic [fhb_pkg::FRAC_BCD_W-1:0] frac_bcd;
  } dab_t;

  // one double-dabble step: add-3 correction on every digit, then shift in
  function automatic logic [23:0] dd_step(logic [23:0] b, logic bit_in);
    logic [23:0] r;
    r = b;
    for (int d = 0; d < 6; d++) begin
      if (r[4*d+:4] >= 4'd5) begin
        r[4*d+:4] = r[4*d+:4] + 4'd3;
      end
    end
    return {r[22:0], bit_in};
  endfunction

  function automatic dab_t dab_stage(dab_t x, int unsigned s);
    dab_t        y;
    int unsigned k;
    logic [23:0] t;
    y = x;
    for (int unsigned j = 0; j < fhb_pkg::BCD_BITS_PER_STAGE; j++) begin
      k = s * fhb_pkg::BCD_BITS_PER_STAGE + j;
      if (k < fhb_pkg::DAY_W) begin
        t = dd_step({12'd0, y.day_bcd}, y.day_bin[fhb_pkg::DAY_W-1]);
        y.day_bcd = t[fhb_pkg::DAY_BCD_W-1:0];
        y.day_bin = y.day_bin << 1;
      end
      if (k < fhb_pkg::SECS_W) begin
        t = dd_step({4'd0, y.secs_bcd}, y.secs_bin[fhb_pkg::SECS_W-1]);
        y.secs_bcd = t[fhb_pkg::SECS_BCD_W-1:0];
        y.secs_bin = y.secs_bin << 1;
      end
      if (k < fhb_pkg::FRAC_W) begin
        t = dd_step({8'd0, y.frac_bcd}, y.frac_bin[fhb_pkg::FRAC_W-1]);
        y.frac_bcd = t[fhb_pkg::FRAC_BCD_W-1:0];
        y.frac_bin = y.frac_bin << 1;
      end
    end
    return y;
  endfunction

  dab_t          in_dab;
  dab_t          stage_d [NS];
  dab_t          stage_q [NS];
  logic [NS-1:0] valid_q;
  logic [NS-1:0] src_valid;
  logic [NS:0]   adv;

  assign in_dab = '{
    frame_number: data_i.frame_number,
    day_bin:      data_i.day_number,
    secs_bin:     data_i.seconds_of_day,
    frac_bin:     data_i.tenth_milliseconds,
    day_bcd:      '0,
    secs_bcd:     '0,
    frac_bcd:     '0
  };

  assign adv[NS] = ready_i;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    assign adv[s] = !valid_q[s] || adv[s+1];
    if (s == 0) begin : g_first
      assign src_valid[s] = valid_i;
      assign stage_d[s]   = dab_stage(in_dab, s);
    end else begin : g_next
      assign src_valid[s] = valid_q[s-1];
      assign stage_d[s]   = dab_stage(stage_q[s-1], s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (adv[s]) begin
          valid_q[s] <= src_valid[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NS; s++) begin
      if (adv[s]) begin
        stage_q[s] <= stage_d[s];
      end
    end
  end

  assign ready_o = adv[0];
  assign valid_o = valid_q[NS-1];
  assign data_o  = '{
    frame_number: stage_q[NS-1].frame_number,
    day_bcd:      stage_q[NS-1].day_bcd,
    secs_bcd:     stage_q[NS-1].secs_bcd,
    frac_bcd:     stage_q[NS-1].frac_bcd
  };

`ifndef SYNTHESIS
  function automatic logic digits_ok(logic [19:0] b);
    logic ok;
    ok = 1'b1;
    for (int d = 0; d < 5; d++) begin
      if (b[4*d+:4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> digits_ok({8'd0, data_o.day_bcd}) && digits_ok(data_o.secs_bcd)
             && digits_ok({4'd0, data_o.frac_bcd}))
    else $error("bcd digit out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> valid_q[NS-1] && !ready_i)
    else $error("bcd pipeline stalled without downstream backpressure");
`endif

endmodule

### rtl/fhb_crc.sv
module fhb_crc (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  fhb_pkg::bcd_t    data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output fhb_pkg::hdr_out_t data_o
);

  localparam int unsigned NS = fhb_pkg::CRC_STAGES;

  typedef struct packed {
    logic [fhb_pkg::FRAME_W-1:0]    frame_number;
    logic [fhb_pkg::WORD_W-1:0]     time_word;
    logic [fhb_pkg::FRAC_BCD_W-1:0] frac_bcd;
    logic [fhb_pkg::CRC_W-1:0]      crc;
  } crc_st_t;

  // serial crc over the message bits owned by stage s, msb first
  function automatic crc_st_t crc_stage(crc_st_t x, int unsigned s);
    crc_st_t                   y;
    logic [fhb_pkg::MSG_W-1:0] msg;
    logic [fhb_pkg::CRC_W-1:0] r;
    logic                      fb;
    int unsigned               k;
    y   = x;
    msg = {x.time_word, x.frac_bcd};
    for (int unsigned j = 0; j < fhb_pkg::CRC_BITS_PER_STAGE; j++) begin
      k  = fhb_pkg::MSG_W - 1 - (s * fhb_pkg::CRC_BITS_PER_STAGE + j);
      fb = msg[k[5:0]] ^ y.crc[0];
      if (fb) begin
        r = (y.crc ^ fhb_pkg::CRC_POLY) | 16'd1;
      end else begin
        r = y.crc & ~16'd1;
      end
      y.crc = {r[0], r[fhb_pkg::CRC_W-1:1]};
    end
    return y;
  endfunction

  function automatic logic [15:0] rev16(logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15-i];
    end
    return r;
  endfunction

  crc_st_t       in_st;
  crc_st_t       stage_d [NS];
  crc_st_t       stage_q [NS];
  logic [NS-1:0] valid_q;
  logic [NS-1:0] src_valid;
  logic [NS:0]   adv;

  assign in_st = '{
    frame_number: data_i.frame_number,
    time_word:    {data_i.day_bcd, data_i.secs_bcd},
    frac_bcd:     data_i.frac_bcd,
    crc:          '0
  };

  assign adv[NS] = ready_i;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    assign adv[s] = !valid_q[s] || adv[s+1];
    if (s == 0) begin : g_first
      assign src_valid[s] = valid_i;
      assign stage_d[s]   = crc_stage(in_st, s);
    end else begin : g_next
      assign src_valid[s] = valid_q[s-1];
      assign stage_d[s]   = crc_stage(stage_q[s-1], s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (adv[s]) begin
          valid_q[s] <= src_valid[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NS; s++) begin
      if (adv[s]) begin
        stage_q[s] <= stage_d[s];
      end
    end
  end

  assign ready_o = adv[0];
  assign valid_o = valid_q[NS-1];
  assign data_o  = '{
    sync_word:         fhb_pkg::SYNC_WORD,
    frame_word:        {fhb_pkg::FRAME_MARKER, stage_q[NS-1].frame_number},
    time_word:         stage_q[NS-1].time_word,
    fraction_crc_word: {stage_q[NS-1].frac_bcd, rev16(stage_q[NS-1].crc)}
  };

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv[1] && valid_q[0] |=> valid_q[1])
    else $error("request lost between crc stages");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> valid_q[NS-1] && !ready_i)
    else $error("crc pipeline stalled without downstream backpressure");
`endif

endmodule

### rtl/frame_header_bcd_crc_builder_unit.sv
// a request passes 3 bcd stages and then 6 crc stages before the header is valid
// throughput: one request per cycle, limited only by downstream ready
// the last crc stage is the output register; stalls back up stage by stage
// reset: asynchronous active-low, clears all stage valid bits; no other state
module frame_header_bcd_crc_builder_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  fhb_in_if.sink           hdr_req_i,
  fhb_out_if.source        hdr_rsp_o
);

  fhb_pkg::hdr_in_t  req_data;
  fhb_pkg::bcd_t     bcd_data;
  fhb_pkg::hdr_out_t rsp_data;
  logic              bcd_valid;
  logic              bcd_ready;
  logic              req_ready;
  logic              rsp_valid;

  assign req_data = '{
    frame_number:       hdr_req_i.frame_number,
    day_number:         hdr_req_i.day_number,
    seconds_of_day:     hdr_req_i.seconds_of_day,
    tenth_milliseconds: hdr_req_i.tenth_milliseconds
  };

  fhb_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hdr_req_i.valid),
    .ready_o (req_ready),
    .data_i  (req_data),
    .valid_o (bcd_valid),
    .ready_i (bcd_ready),
    .data_o  (bcd_data)
  );

  fhb_crc u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bcd_valid),
    .ready_o (bcd_ready),
    .data_i  (bcd_data),
    .valid_o (rsp_valid),
    .ready_i (hdr_rsp_o.ready),
    .data_o  (rsp_data)
  );

  assign hdr_req_i.ready             = req_ready;
  assign hdr_rsp_o.valid             = rsp_valid;
  assign hdr_rsp_o.sync_word         = rsp_data.sync_word;
  assign hdr_rsp_o.frame_word        = rsp_data.frame_word;
  assign hdr_rsp_o.time_word         = rsp_data.time_word;
  assign hdr_rsp_o.fraction_crc_word = rsp_data.fraction_crc_word;

endmodule

### dv/frame_header_checker.sv
`timescale 1ns / 1ps

module frame_header_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  fhb_in_if           hdr_req_i,
  fhb_out_if          hdr_rsp_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);

  fhb_pkg::hdr_out_t hdr_q[$];
  fhb_pkg::hdr_out_t want;
  fhb_pkg::hdr_in_t  req;

  function automatic logic [19:0] dec_to_bcd(int unsigned v, int unsigned digits);
    logic [19:0] d;
    d = '0;
    for (int k = 0; k < digits; k++) begin
      d[4*k +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return d;
  endfunction

  function automatic fhb_pkg::hdr_out_t build_header(fhb_pkg::hdr_in_t r);
    fhb_pkg::hdr_out_t h;
    logic [11:0]       day_d;
    logic [19:0]       secs_d;
    logic [15:0]       frac_d;
    logic [47:0]       msg;
    logic [15:0]       crc;
    logic [15:0]       crc_rev;
    day_d  = 12'(dec_to_bcd(r.day_number, fhb_pkg::DAY_DIGITS));
    secs_d = dec_to_bcd(r.seconds_of_day, fhb_pkg::SECS_DIGITS);
    frac_d = 16'(dec_to_bcd(r.tenth_milliseconds, fhb_pkg::FRAC_DIGITS));
    h.sync_word  = fhb_pkg::SYNC_WORD;
    h.frame_word = {fhb_pkg::FRAME_MARKER, r.frame_number};
    h.time_word  = {day_d, secs_d};
    msg = {h.time_word, frac_d};
    // serial crc, msb first, rotate right each bit
    crc = '0;
    for (int k = fhb_pkg::MSG_W - 1; k >= 0; k--) begin
      if (msg[k] ^ crc[0]) begin
        crc    = crc ^ fhb_pkg::CRC_POLY;
        crc[0] = 1'b1;
      end else begin
        crc[0] = 1'b0;
      end
      crc = {crc[0], crc[15:1]};
    end
    for (int k = 0; k < 16; k++) begin
      crc_rev[15-k] = crc[k];
    end
    h.fraction_crc_word = {frac_d, crc_rev};
    return h;
  endfunction

  task automatic check_word(string what, logic [31:0] want_w, logic [31:0] got_w);
    if (got_w !== want_w) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_w, got_w);
      err_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q.delete();
      err_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (hdr_req_i.valid && hdr_req_i.ready) begin
        req.frame_number       = hdr_req_i.frame_number;
        req.day_number         = hdr_req_i.day_number;
        req.seconds_of_day     = hdr_req_i.seconds_of_day;
        req.tenth_milliseconds = hdr_req_i.tenth_milliseconds;
        hdr_q.push_back(build_header(req));
      end
      if (hdr_rsp_i.valid && hdr_rsp_i.ready) begin
        if (hdr_q.size() == 0) begin
          $display("%0t: unexpected header: expected none, got %h %h %h %h", $time,
                   hdr_rsp_i.sync_word, hdr_rsp_i.frame_word, hdr_rsp_i.time_word,
                   hdr_rsp_i.fraction_crc_word);
          err_cnt_o++;
        end else begin
          want = hdr_q.pop_front();
          check_word("sync_word", want.sync_word, hdr_rsp_i.sync_word);
          check_word("frame_word", want.frame_word, hdr_rsp_i.frame_word);
          check_word("time_word", want.time_word, hdr_rsp_i.time_word);
          check_word("fraction_crc_word", want.fraction_crc_word,
                     hdr_rsp_i.fraction_crc_word);
        end
      end
      pending_o = hdr_q.size();
    end
  end

endmodule

### dv/frame_header_bcd_crc_builder_unit_tb.sv
`timescale 1ns / 1ps

module frame_header_bcd_crc_builder_unit_tb;

  localparam int unsigned NUM_RANDOM = 1200;

  localparam fhb_pkg::hdr_in_t CORNERS [18] = '{
    '{16'h0000, 10'd0,    17'd0,      14'd0},
    '{16'hffff, 10'd999,  17'd86399,  14'd9999},
    '{16'hffff, 10'h3ff,  17'h1ffff,  14'h3fff},
    '{16'h5555, 10'h155,  17'h15555,  14'h1555},
    '{16'haaaa, 10'h2aa,  17'h0aaaa,  14'h2aaa},
    '{16'h0001, 10'd1023, 17'd0,      14'd0},
    '{16'h8000, 10'd1000, 17'd99999,  14'd0},
    '{16'h0000, 10'd0,    17'd100000, 14'd0},
    '{16'h0000, 10'd0,    17'd131071, 14'd10000},
    '{16'h1234, 10'd0,    17'd0,      14'd16383},
    '{16'h0000, 10'd9,    17'd9,      14'd9},
    '{16'h0000, 10'd10,   17'd10,     14'd10},
    '{16'h0000, 10'd99,   17'd9999,   14'd999},
    '{16'h0000, 10'd100,  17'd10000,  14'd1000},
    '{16'h7fff, 10'd365,  17'd43200,  14'd5000},
    '{16'h0000, 10'd0,    17'd1,      14'd1},
    '{16'hffff, 10'd512,  17'd65536,  14'd8192},
    '{16'h00ff, 10'd256,  17'd86400,  14'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned err_cnt;
  int unsigned pending;
  bit          steady;
  bit          hold_off;

  fhb_in_if  hdr_req ();
  fhb_out_if hdr_rsp ();

  frame_header_bcd_crc_builder_unit u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .hdr_req_i (hdr_req),
    .hdr_rsp_o (hdr_rsp)
  );

  frame_header_checker u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .hdr_req_i (hdr_req),
    .hdr_rsp_i (hdr_rsp),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic fhb_pkg::hdr_in_t pick_hdr();
    fhb_pkg::hdr_in_t r;
    r.frame_number = 16'($urandom);
    case ($urandom_range(0, 9))
      7: begin
        r.day_number         = 10'($urandom);
        r.seconds_of_day     = 17'($urandom);
        r.tenth_milliseconds = 14'($urandom);
      end
      8: begin
        // near and past the digit limits
        r.day_number         = 10'($urandom_range(990, 1023));
        r.seconds_of_day     = 17'($urandom_range(99990, 131071));
        r.tenth_milliseconds = 14'($urandom_range(9990, 16383));
      end
      default: begin
        r.day_number         = 10'($urandom_range(0, 999));
        r.seconds_of_day     = 17'($urandom_range(0, 86399));
        r.tenth_milliseconds = 14'($urandom_range(0, 9999));
      end
    endcase
    return r;
  endfunction

  task automatic offer_hdr(fhb_pkg::hdr_in_t r, bit gaps);
    if (gaps && !steady && $urandom_range(0, 3) == 0) begin
      hdr_req.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    hdr_req.valid              <= 1'b1;
    hdr_req.frame_number       <= r.frame_number;
    hdr_req.day_number         <= r.day_number;
    hdr_req.seconds_of_day     <= r.seconds_of_day;
    hdr_req.tenth_milliseconds <= r.tenth_milliseconds;
    do @(posedge clk_i); while (!hdr_req.ready);
  endtask

  // request side
  initial begin
    steady   = 1'b0;
    hold_off = 1'b0;
    hdr_req.valid              <= 1'b0;
    hdr_req.frame_number       <= '0;
    hdr_req.day_number         <= '0;
    hdr_req.seconds_of_day     <= '0;
    hdr_req.tenth_milliseconds <= '0;
    wait (rst_ni);
    @(posedge clk_i);
    foreach (CORNERS[i]) offer_hdr(CORNERS[i], 1'b1);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 400) hold_off = 1'b1;
      if (n == NUM_RANDOM - 150) steady = 1'b1;
      offer_hdr(pick_hdr(), !(n >= 400 && n < 460));
    end
    hdr_req.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("** frame_header_bcd_crc_builder_unit: PASSED **");
    end else begin
      $display("** frame_header_bcd_crc_builder_unit: FAILED **");
    end
    $finish;
  end

  // response side
  initial begin
    hdr_rsp.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off) begin
        // long hold so the pipe fills and backs up
        hdr_rsp.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        hdr_rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
        if (!steady && !hold_off) begin
          hdr_rsp.ready <= 1'b0;
          repeat ($urandom_range(1, 11)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("** frame_header_bcd_crc_builder_unit: FAILED **");
    $finish;
  end

endmodule

### files.f
rtl/fhb_pkg.sv
rtl/fhb_in_if.sv
rtl/fhb_out_if.sv
rtl/fhb_bcd.sv
rtl/fhb_crc.sv
rtl/frame_header_bcd_crc_builder_unit.sv
dv/frame_header_checker.sv
dv/frame_header_bcd_crc_builder_unit_tb.sv
